// ----- hw/rtl/hgpp_pkg.sv -----
// ----------------------------------------------------------------------------
// hgpp_pkg
// shared constants, codes and mixing helpers of the hashed grid point picker
// ----------------------------------------------------------------------------
package hgpp_pkg;

  localparam int unsigned HashW   = 32;
  localparam int unsigned RegionW = 21;
  localparam int unsigned GridW   = 28;
  localparam int unsigned PitchW  = 8;
  localparam int unsigned SizeW   = 9;
  localparam int unsigned LocalW  = 8;
  localparam int unsigned CfgAddrW = 2;

  // coordinate primes and murmur finaliser multipliers
  localparam logic [HashW-1:0] PrimeX = 32'd374761393;
  localparam logic [HashW-1:0] PrimeZ = 32'd668265263;
  localparam logic [HashW-1:0] ZSalt  = 32'd3039394381;
  localparam logic [HashW-1:0] Mix1   = 32'h85ebca6b;
  localparam logic [HashW-1:0] Mix2   = 32'hc2b2ae35;

  localparam logic [HashW-1:0]  SeedReset   = 32'd123;
  localparam logic [PitchW-1:0] PitchReset  = 8'd5;
  localparam logic [SizeW-1:0]  SizeReset   = 9'd32;
  localparam logic [SizeW-1:0]  SizeMaxUsed = 9'd256;

  typedef enum logic [1:0] {
    VerdictPlaced    = 2'd0,
    VerdictNotLowest = 2'd1,
    VerdictOutside   = 2'd2
  } verdict_e;

  typedef enum logic [CfgAddrW-1:0] {
    RegHashSeed   = 2'd0,
    RegCellPitch  = 2'd1,
    RegRegionSize = 2'd2
  } reg_idx_e;

  // xor-shift steps of the finaliser
  function automatic logic [HashW-1:0] xs16(input logic [HashW-1:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [HashW-1:0] xs13(input logic [HashW-1:0] v);
    return v ^ (v >> 13);
  endfunction

endpackage

// ----- hw/rtl/hgpp_hash9.sv -----
// ----------------------------------------------------------------------------
// hgpp_hash9
// pipelined hashes of a cell and its eight neighbours, four register stages
// ----------------------------------------------------------------------------
module hgpp_hash9 (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic [hgpp_pkg::HashW-1:0]    seed_i,
  input  logic [hgpp_pkg::HashW-1:0]    mx_i,
  input  logic [hgpp_pkg::HashW-1:0]    mz_i,
  output logic [8:0][hgpp_pkg::HashW-1:0] hash_o
);

  logic [hgpp_pkg::HashW-1:0] vx [3];
  logic [hgpp_pkg::HashW-1:0] vz [3];
  logic [hgpp_pkg::HashW-1:0] ax_q [3];
  logic [hgpp_pkg::HashW-1:0] az_q [3];
  logic [hgpp_pkg::HashW-1:0] bx_q [3];
  logic [hgpp_pkg::HashW-1:0] bz_q [3];
  logic [hgpp_pkg::HashW-1:0] c_q  [9];
  logic [hgpp_pkg::HashW-1:0] d_q  [9];

  // (g + d) * prime = g * prime + d * prime
  assign vx[0] = mx_i - hgpp_pkg::PrimeX;
  assign vx[1] = mx_i;
  assign vx[2] = mx_i + hgpp_pkg::PrimeX;
  assign vz[0] = mz_i - hgpp_pkg::PrimeZ;
  assign vz[1] = mz_i;
  assign vz[2] = mz_i + hgpp_pkg::PrimeZ;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        ax_q[k] <= hgpp_pkg::xs16(vx[k]) * hgpp_pkg::Mix1;
        az_q[k] <= hgpp_pkg::xs16(vz[k]) * hgpp_pkg::Mix1;
        bx_q[k] <= hgpp_pkg::xs13(ax_q[k]) * hgpp_pkg::Mix2;
        bz_q[k] <= hgpp_pkg::xs13(az_q[k]) * hgpp_pkg::Mix2;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          c_q[i*3+j] <= hgpp_pkg::xs16(seed_i ^ hgpp_pkg::xs16(bx_q[i]) ^
                                       hgpp_pkg::xs16(bz_q[j])) * hgpp_pkg::Mix1;
        end
      end
      for (int n = 0; n < 9; n++) begin
        d_q[n] <= hgpp_pkg::xs13(c_q[n]) * hgpp_pkg::Mix2;
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      hash_o[n] = hgpp_pkg::xs16(d_q[n]);
    end
  end

endmodule

// ----- hw/rtl/hashed_grid_point_picker_top.sv -----
// ----------------------------------------------------------------------------
// hashed_grid_point_picker_top
// jittered grid point picker with local-minimum hash selection
// ----------------------------------------------------------------------------
// One cell word enters per clock and one result word leaves per clock while
// the output is not stalled. The datapath is a seven-stage pipeline whose
// stages follow the chain of multiplies in the hash (coordinate prime, then
// two finaliser multiplies for the coordinate hash and two for the cell hash,
// each with its own register) plus the neighbour compare and the bounds test.
// The whole pipeline moves together: it advances whenever the output register
// is empty or its word is being taken, so a stalled output holds every stage
// in place and the block keeps taking words while nothing waits downstream.
// Configuration writes take effect at once and are meant to be made only while
// the pipeline is empty. A pitch of zero acts as one, a region size above 256
// acts as 256, and a region size of zero rejects every locally minimal cell.
// ----------------------------------------------------------------------------
module hashed_grid_point_picker_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [hgpp_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [hgpp_pkg::HashW-1:0]       cfg_wdata_i,
  // cell words in
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [hgpp_pkg::RegionW-1:0] region_x_i,
  input  logic signed [hgpp_pkg::RegionW-1:0] region_z_i,
  input  logic signed [hgpp_pkg::GridW-1:0]   grid_x_i,
  input  logic signed [hgpp_pkg::GridW-1:0]   grid_z_i,
  // result words out
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       verdict_o,
  output logic [hgpp_pkg::LocalW-1:0]      local_x_o,
  output logic [hgpp_pkg::LocalW-1:0]      local_z_o,
  output logic [hgpp_pkg::HashW-1:0]       cell_hash_o
);

  localparam int unsigned W = hgpp_pkg::HashW;

  // geometry carried alongside the hash pipeline
  typedef struct packed {
    logic [W-1:0] cx;    // cell corner x
    logic [W-1:0] cz;    // cell corner z
    logic [W-1:0] minx;  // region origin x
    logic [W-1:0] minz;  // region origin z
  } geo_t;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [W-1:0]                    seed_q;
  logic [hgpp_pkg::PitchW-1:0]     pitch_q;
  logic [hgpp_pkg::SizeW-1:0]      size_q;
  logic [hgpp_pkg::PitchW-1:0]     pitch_eff;
  logic [hgpp_pkg::SizeW-1:0]      size_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= hgpp_pkg::SeedReset;
      pitch_q <= hgpp_pkg::PitchReset;
      size_q  <= hgpp_pkg::SizeReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        hgpp_pkg::RegHashSeed:   seed_q  <= cfg_wdata_i;
        hgpp_pkg::RegCellPitch:  pitch_q <= cfg_wdata_i[hgpp_pkg::PitchW-1:0];
        hgpp_pkg::RegRegionSize: size_q  <= cfg_wdata_i[hgpp_pkg::SizeW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // pitch of zero behaves as one, oversize regions clamp to 256
  assign pitch_eff = (pitch_q == '0) ? hgpp_pkg::PitchW'(1) : pitch_q;
  assign size_eff  = (size_q > hgpp_pkg::SizeMaxUsed) ? hgpp_pkg::SizeMaxUsed : size_q;

  // ---------------------------------------------------------------------------
  // pipeline control: all stages advance together
  // ---------------------------------------------------------------------------
  logic       adv;
  logic [6:1] vld_q;
  logic       out_valid_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[5:1], in_valid_i};
      out_valid_q <= vld_q[6];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: sign extension and coordinate prime products
  // ---------------------------------------------------------------------------
  logic [W-1:0] gx_ext, gz_ext, rx_ext, rz_ext;
  logic [W-1:0] mx1_q, mz1_q, gx1_q, gz1_q, rx1_q, rz1_q;

  assign gx_ext = W'(grid_x_i);
  assign gz_ext = W'(grid_z_i);
  assign rx_ext = W'(region_x_i);
  assign rz_ext = W'(region_z_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx1_q <= gx_ext * hgpp_pkg::PrimeX;
      mz1_q <= gz_ext * hgpp_pkg::PrimeZ;
      gx1_q <= gx_ext;
      gz1_q <= gz_ext;
      rx1_q <= rx_ext;
      rz1_q <= rz_ext;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2 to 5: nine cell hashes, geometry carried along
  // ---------------------------------------------------------------------------
  logic [8:0][W-1:0] hash9;
  geo_t              geo2_q, geo3_q, geo4_q, geo5_q, geo6_q;

  hgpp_hash9 u_hash9 (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .seed_i (seed_q),
    .mx_i   (mx1_q),
    .mz_i   (mz1_q),
    .hash_o (hash9)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      geo2_q.cx   <= gx1_q * W'(pitch_eff);
      geo2_q.cz   <= gz1_q * W'(pitch_eff);
      geo2_q.minx <= rx1_q * W'(size_eff);
      geo2_q.minz <= rz1_q * W'(size_eff);
      geo3_q      <= geo2_q;
      geo4_q      <= geo3_q;
      geo5_q      <= geo4_q;
      geo6_q      <= geo5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: local-minimum test and jitter
  // ---------------------------------------------------------------------------
  logic [W-1:0]               hsh, hsh_z, jx_prod, jz_prod;
  logic                       lowest;
  logic [W-1:0]               h6_q;
  logic                       low6_q;
  logic [hgpp_pkg::PitchW-1:0] jx6_q, jz6_q;

  always_comb begin
    hsh    = hash9[4];
    hsh_z  = hsh ^ hgpp_pkg::ZSalt;
    lowest = 1'b1;
    // equal hashes do not reject the centre cell
    for (int n = 0; n < 9; n++) begin
      if (n != 4 && hash9[n] < hsh) begin
        lowest = 1'b0;
      end
    end
    // top 24 hash bits as a fraction, scaled by the pitch
    jx_prod = {8'd0, hsh[W-1:8]} * W'(pitch_eff);
    jz_prod = {8'd0, hsh_z[W-1:8]} * W'(pitch_eff);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h6_q   <= hsh;
      low6_q <= lowest;
      jx6_q  <= jx_prod[W-1:W-hgpp_pkg::PitchW];
      jz6_q  <= jz_prod[W-1:W-hgpp_pkg::PitchW];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: bounds test into the output register
  // ---------------------------------------------------------------------------
  logic [W-1:0]                px, pz, maxx, maxz, offx, offz;
  logic                        outside;
  hgpp_pkg::verdict_e          verdict_d, verdict_q;
  logic [hgpp_pkg::LocalW-1:0] lx_d, lz_d, lx_q, lz_q;
  logic [W-1:0]                hash_q;

  always_comb begin
    px   = geo6_q.cx + W'(jx6_q);
    pz   = geo6_q.cz + W'(jz6_q);
    maxx = geo6_q.minx + W'(size_eff) - W'(1);
    maxz = geo6_q.minz + W'(size_eff) - W'(1);
    offx = px - geo6_q.minx;
    offz = pz - geo6_q.minz;
    // bounds compare as signed after wrapping
    outside = (size_eff == '0) ||
              ($signed(px) < $signed(geo6_q.minx)) || ($signed(maxx) < $signed(px)) ||
              ($signed(pz) < $signed(geo6_q.minz)) || ($signed(maxz) < $signed(pz));
    lx_d = '0;
    lz_d = '0;
    if (!low6_q) begin
      verdict_d = hgpp_pkg::VerdictNotLowest;
    end else if (outside) begin
      verdict_d = hgpp_pkg::VerdictOutside;
    end else begin
      verdict_d = hgpp_pkg::VerdictPlaced;
      lx_d      = offx[hgpp_pkg::LocalW-1:0];
      lz_d      = offz[hgpp_pkg::LocalW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      verdict_q <= verdict_d;
      lx_q      <= lx_d;
      lz_q      <= lz_d;
      hash_q    <= h6_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign local_x_o   = lx_q;
  assign local_z_o   = lz_q;
  assign cell_hash_o = hash_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a held output freezes every stage valid bit
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q) && out_valid_q)
    else $error("pipeline moved under a stalled output");

  // an accepted word always lands in stage one
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[1])
    else $error("accepted word lost at pipeline entry");

  // a placed point lies inside the region
  a_placed_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o == hgpp_pkg::VerdictPlaced |->
      ({1'b0, local_x_o} < size_eff) && ({1'b0, local_z_o} < size_eff))
    else $error("placed point outside region");

  // rejected cells report zero local position
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o != hgpp_pkg::VerdictPlaced |->
      local_x_o == '0 && local_z_o == '0)
    else $error("rejected word carries a position");

endmodule
